[rtl/core/mksc_pkg.sv]
// Package: constants, codes, types and the base colour table of the mute knob controller.
`default_nettype none

package mksc_pkg;

  // Sizing
  localparam int NUM_MODES   = 7;
  localparam int FRAME_MAX   = 1024;
  localparam int MODE_W      = 3;
  localparam int ENTRY_W     = $clog2(NUM_MODES);
  localparam int TRIP_W      = $clog2(NUM_MODES + 1);
  localparam int ADDR_W      = ENTRY_W + 1;
  localparam int LEN_W       = $clog2(FRAME_MAX + 1);
  localparam int CMD_W       = 3;
  localparam int BYTE_W      = 8;
  localparam int COLOUR_W    = 3 * BYTE_W;
  localparam int VOL_W       = 7;
  localparam int PROD_W      = BYTE_W + VOL_W;
  localparam int RECIP_W     = 13;
  localparam int QUOT_W      = PROD_W + RECIP_W;
  localparam int TICK_W      = 32;
  localparam int COMM_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Divide by 100 as multiply by reciprocal, exact for products below 43690
  localparam logic [RECIP_W-1:0] RECIP_100   = RECIP_W'(5243);
  localparam int                 RECIP_SHIFT = 19;

  localparam logic [MODE_W-1:0] IDLE_MODE  = MODE_W'(NUM_MODES - 1);
  localparam logic [MODE_W-1:0] MODE_MUTED = MODE_W'(1);
  localparam logic [VOL_W-1:0]  VOL_CAP    = VOL_W'(100);

  // Input commands
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PRESS   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CW      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CCW     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FRAME   = 3'd5;

  // Bytes sent to the host
  localparam logic [BYTE_W-1:0] KEY_UNMUTE  = 8'hf1;
  localparam logic [BYTE_W-1:0] KEY_MUTE    = 8'hf2;
  localparam logic [BYTE_W-1:0] KEY_VOL_UP  = 8'hf8;
  localparam logic [BYTE_W-1:0] KEY_VOL_DN  = 8'hf9;
  localparam logic [BYTE_W-1:0] ALIVE_REPLY = 8'h55;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMM_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LED_MAX      = 2'd2;

  typedef struct packed {
    logic [15:0]       long_press;
    logic [COMM_W-1:0] comm_timeout;
    logic [BYTE_W-1:0] led_max;
  } cfg_t;

  // One item on its way from the control stage to the scaling pipeline
  typedef struct packed {
    logic                tx_valid;
    logic [BYTE_W-1:0]   tx_byte;
    logic                led_valid;
    logic [MODE_W-1:0]   mode;
    logic [VOL_W-1:0]    vol;
    logic                scale;
    logic                use_base;
    logic                bypass;
    logic [COLOUR_W-1:0] byp_colour;
  } item_t;

  // Colour of each mode before any host load
  function automatic logic [COLOUR_W-1:0] base_colour(input logic [MODE_W-1:0] m);
    logic [COLOUR_W-1:0] c;
    unique case (m)
      3'd0:    c = 24'h001f00;
      3'd1:    c = 24'h1f0000;
      3'd2:    c = 24'h200030;
      3'd3:    c = 24'h574c3f;
      3'd4:    c = 24'h346596;
      3'd5:    c = 24'h200030;
      3'd6:    c = 24'h300030;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Keep-alive request pattern, one byte per frame position
  function automatic logic [BYTE_W-1:0] alive_byte(input logic [1:0] pos);
    logic [BYTE_W-1:0] b;
    unique case (pos)
      2'd0: b = 8'h11;
      2'd1: b = 8'h22;
      2'd2: b = 8'h33;
      2'd3: b = 8'h44;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[rtl/core/mksc_ifs.sv]
// Interfaces: item, result and configuration channels of the mute knob controller.
`default_nettype none

interface mksc_in_if;
  logic                         valid;
  logic                         ready;
  logic [mksc_pkg::CMD_W-1:0]   cmd;
  logic [mksc_pkg::BYTE_W-1:0]  rx_byte;
  logic                         rx_last;
  modport source (output valid, cmd, rx_byte, rx_last, input ready);
  modport sink   (input valid, cmd, rx_byte, rx_last, output ready);
endinterface

interface mksc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         tx_valid;
  logic [mksc_pkg::BYTE_W-1:0]  tx_byte;
  logic                         led_valid;
  logic [mksc_pkg::BYTE_W-1:0]  led_red;
  logic [mksc_pkg::BYTE_W-1:0]  led_green;
  logic [mksc_pkg::BYTE_W-1:0]  led_blue;
  logic [mksc_pkg::MODE_W-1:0]  mode_now;
  modport source (output valid, tx_valid, tx_byte, led_valid, led_red, led_green,
                  led_blue, mode_now, input ready);
  modport sink   (input valid, tx_valid, tx_byte, led_valid, led_red, led_green,
                  led_blue, mode_now, output ready);
endinterface

interface mksc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mksc_pkg::CFG_IDX_W-1:0]  index;
  logic [mksc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/mksc_colour_ram.sv]
// Colour table memory: two banks per mode, one write and one registered read per cycle.
`default_nettype none

module mksc_colour_ram (
  input  logic                              clk,
  input  logic                              we,
  input  logic [mksc_pkg::ADDR_W-1:0]       waddr,
  input  logic [mksc_pkg::COLOUR_W-1:0]     wdata,
  input  logic                              re,
  input  logic [mksc_pkg::ADDR_W-1:0]       raddr,
  output logic [mksc_pkg::COLOUR_W-1:0]     rdata
);
  import mksc_pkg::*;

  logic [COLOUR_W-1:0] mem [2**ADDR_W];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/mksc_ctrl.sv]
// Control stage: knob and frame handling, link timeout, bank select and colour read issue.
`default_nettype none

module mksc_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  mksc_in_if.sink                        items,
  input  mksc_pkg::cfg_t                 cfg,
  input  logic                           take,
  output mksc_pkg::item_t                s1,
  output logic                           s1_valid,
  output logic                           ram_we,
  output logic [mksc_pkg::ADDR_W-1:0]    ram_waddr,
  output logic [mksc_pkg::COLOUR_W-1:0]  ram_wdata,
  output logic                           ram_re,
  output logic [mksc_pkg::ADDR_W-1:0]    ram_raddr
);
  import mksc_pkg::*;

  // Architectural state
  logic [MODE_W-1:0]    mode, mode_next;
  logic [MODE_W-1:0]    shown_mode;
  logic                 display_stale;
  logic [BYTE_W-1:0]    volume, volume_next;
  logic [TICK_W-1:0]    tick_count, tick_count_next;
  logic [TICK_W-1:0]    press_time, press_time_next;
  logic [COMM_W-1:0]    since_comm, since_comm_next;
  logic [LEN_W-1:0]     frame_len, frame_len_next;
  logic [1:0]           pos3, pos3_next;
  logic [TRIP_W-1:0]    trip, trip_next;
  logic                 match, match_next;
  logic [BYTE_W-1:0]    first_byte, first_byte_next;
  logic [BYTE_W-1:0]    stage_r, stage_r_next;
  logic [BYTE_W-1:0]    stage_g, stage_g_next;
  logic [NUM_MODES-1:0] bank, bank_next;
  logic [NUM_MODES-1:0] loaded, loaded_next;

  // Per-item working values
  logic                 fire;
  logic [LEN_W-1:0]     len_e;
  logic [1:0]           pos3_e;
  logic [TRIP_W-1:0]    trip_e;
  logic                 match_e;
  logic                 frame_set;
  logic [BYTE_W-1:0]    clamped;
  logic [TICK_W-1:0]    elapsed;
  logic [ENTRY_W-1:0]   wr_entry;
  logic [ENTRY_W-1:0]   rd_entry;
  item_t                item;

  assign fire        = items.valid && items.ready;
  assign items.ready = !s1_valid || take;
  assign ram_re      = fire;
  assign elapsed     = tick_count - press_time;
  assign clamped     = (items.rx_byte > cfg.led_max) ? cfg.led_max : items.rx_byte;
  assign wr_entry    = trip[ENTRY_W-1:0];

  // Next state for the item at the port
  always_comb begin
    mode_next       = mode;
    volume_next     = volume;
    tick_count_next = tick_count;
    press_time_next = press_time;
    since_comm_next = since_comm;
    frame_len_next  = frame_len;
    pos3_next       = pos3;
    trip_next       = trip;
    match_next      = match;
    first_byte_next = first_byte;
    stage_r_next    = stage_r;
    stage_g_next    = stage_g;
    bank_next       = bank;
    loaded_next     = loaded;
    len_e           = frame_len;
    pos3_e          = pos3;
    trip_e          = trip;
    match_e         = match;
    frame_set       = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = {~bank[wr_entry], wr_entry};
    ram_wdata       = {stage_r, stage_g, clamped};
    item.tx_valid   = 1'b0;
    item.tx_byte    = '0;

    unique case (items.cmd)
      CMD_TICK: begin
        tick_count_next = tick_count + TICK_W'(1);
        if (since_comm != {COMM_W{1'b1}}) begin
          since_comm_next = since_comm + COMM_W'(1);
        end
      end
      CMD_PRESS: begin
        item.tx_valid   = 1'b1;
        item.tx_byte    = (mode == MODE_MUTED) ? KEY_UNMUTE : KEY_MUTE;
        press_time_next = tick_count;
      end
      CMD_RELEASE: begin
        if (mode == MODE_MUTED && elapsed > TICK_W'(cfg.long_press)) begin
          item.tx_valid = 1'b1;
          item.tx_byte  = KEY_UNMUTE;
        end
      end
      CMD_CW: begin
        item.tx_valid = 1'b1;
        item.tx_byte  = KEY_VOL_UP;
      end
      CMD_CCW: begin
        item.tx_valid = 1'b1;
        item.tx_byte  = KEY_VOL_DN;
      end
      CMD_FRAME: begin
        // Count the byte; stage colour bytes and write completed triples to the spare bank
        if (frame_len < LEN_W'(FRAME_MAX)) begin
          len_e  = frame_len + LEN_W'(1);
          pos3_e = (pos3 == 2'd2) ? 2'd0 : pos3 + 2'd1;
          if (pos3 == 2'd0) begin
            stage_r_next = clamped;
          end
          if (pos3 == 2'd1) begin
            stage_g_next = clamped;
          end
          if (pos3 == 2'd2 && trip < TRIP_W'(NUM_MODES)) begin
            ram_we = fire;
            trip_e = trip + TRIP_W'(1);
          end
          if (frame_len == '0) begin
            first_byte_next = items.rx_byte;
          end
          if (frame_len < LEN_W'(4)) begin
            match_e = (frame_len == '0 || match) &&
                      (items.rx_byte == alive_byte(frame_len[1:0]));
          end
        end
        frame_len_next = len_e;
        pos3_next      = pos3_e;
        trip_next      = trip_e;
        match_next     = match_e;

        // Act on the frame at its last byte
        if (items.rx_last) begin
          frame_len_next  = '0;
          pos3_next       = 2'd0;
          trip_next       = '0;
          since_comm_next = '0;
          if (len_e == LEN_W'(4)) begin
            if (match_e) begin
              item.tx_valid = 1'b1;
              item.tx_byte  = ALIVE_REPLY;
            end
          end else if (len_e == LEN_W'(2)) begin
            mode_next   = (first_byte >= BYTE_W'(NUM_MODES)) ? IDLE_MODE
                                                           : first_byte[MODE_W-1:0];
            volume_next = items.rx_byte;
            frame_set   = 1'b1;
          end else if (len_e >= LEN_W'(3) && pos3_e == 2'd0) begin
            // Commit the freshly written entries by flipping their banks
            for (int j = 0; j < NUM_MODES; j++) begin
              if (TRIP_W'(j) < trip_e) begin
                bank_next[j]   = ~bank[j];
                loaded_next[j] = 1'b1;
              end
            end
            frame_set = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    // Link timeout forces idle
    if (since_comm_next > cfg.comm_timeout) begin
      mode_next = IDLE_MODE;
    end

    // Display request and colour read for the mode after this item
    rd_entry        = mode_next[ENTRY_W-1:0];
    ram_raddr       = {bank_next[rd_entry], rd_entry};
    item.led_valid  = display_stale || frame_set || (mode_next != shown_mode);
    item.mode       = mode_next;
    item.vol        = (volume_next > BYTE_W'(VOL_CAP)) ? VOL_CAP : volume_next[VOL_W-1:0];
    item.scale      = (mode_next <= MODE_MUTED);
    item.use_base   = !loaded_next[rd_entry];
    item.bypass     = ram_we && (ram_waddr == ram_raddr);
    item.byp_colour = ram_wdata;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= IDLE_MODE;
      shown_mode    <= '0;
      display_stale <= 1'b1;
      volume        <= '0;
      tick_count    <= '0;
      press_time    <= '0;
      since_comm    <= '0;
      frame_len     <= '0;
      pos3          <= 2'd0;
      trip          <= '0;
      bank          <= '0;
      loaded        <= '0;
      s1_valid      <= 1'b0;
    end else begin
      if (fire) begin
        mode          <= mode_next;
        shown_mode    <= mode_next;
        display_stale <= 1'b0;
        volume        <= volume_next;
        tick_count    <= tick_count_next;
        press_time    <= press_time_next;
        since_comm    <= since_comm_next;
        frame_len     <= frame_len_next;
        pos3          <= pos3_next;
        trip          <= trip_next;
        bank          <= bank_next;
        loaded        <= loaded_next;
        s1_valid      <= 1'b1;
      end else if (take) begin
        s1_valid      <= 1'b0;
      end
    end
  end

  // Frame staging and stage-one payload
  always_ff @(posedge clk) begin
    if (fire) begin
      match      <= match_next;
      first_byte <= first_byte_next;
      stage_r    <= stage_r_next;
      stage_g    <= stage_g_next;
      s1         <= item;
    end
  end

endmodule

`default_nettype wire

[rtl/core/mksc_scale.sv]
// Scaling pipeline: colour select, volume multiply, divide by 100 and result register.
`default_nettype none

module mksc_scale (
  input  logic                           clk,
  input  logic                           rst,
  input  mksc_pkg::item_t                s1,
  input  logic                           s1_valid,
  input  logic [mksc_pkg::COLOUR_W-1:0]  rdata,
  output logic                           take,
  mksc_out_if.source                     results
);
  import mksc_pkg::*;

  logic                s2_valid;
  logic                s2_free;
  logic                out_free;
  logic                s2_tx_valid;
  logic [BYTE_W-1:0]   s2_tx_byte;
  logic                s2_led_valid;
  logic [MODE_W-1:0]   s2_mode;
  logic                s2_scale;
  logic [BYTE_W-1:0]   s2_chan [3];
  logic [PROD_W-1:0]   s2_prod [3];
  logic [COLOUR_W-1:0] colour;
  logic [BYTE_W-1:0]   chan [3];
  logic [BYTE_W-1:0]   level [3];

  assign out_free = !results.valid || results.ready;
  assign s2_free  = !s2_valid || out_free;
  assign take     = s2_free;

  // Pick table data, same-cycle write data, or the base colour
  always_comb begin
    if (s1.use_base) begin
      colour = base_colour(s1.mode);
    end else if (s1.bypass) begin
      colour = s1.byp_colour;
    end else begin
      colour = rdata;
    end
    chan[0] = colour[23:16];
    chan[1] = colour[15:8];
    chan[2] = colour[7:0];
  end

  // Finish each channel: unscaled modes pass through; else quotient by 100, raised to 1 for a nonzero input
  always_comb begin
    logic [QUOT_W-1:0] wide;
    logic [BYTE_W-1:0] q;
    for (int k = 0; k < 3; k++) begin
      wide = {{RECIP_W{1'b0}}, s2_prod[k]} * {{PROD_W{1'b0}}, RECIP_100};
      q    = wide[RECIP_SHIFT +: BYTE_W];
      if (!s2_scale) begin
        level[k] = s2_chan[k];
      end else if (q == '0 && s2_chan[k] != '0) begin
        level[k] = BYTE_W'(1);
      end else begin
        level[k] = q;
      end
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid      <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (out_free) begin
        results.valid <= s2_valid;
      end
    end
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_tx_valid  <= s1.tx_valid;
      s2_tx_byte   <= s1.tx_byte;
      s2_led_valid <= s1.led_valid;
      s2_mode      <= s1.mode;
      s2_scale     <= s1.scale;
      for (int k = 0; k < 3; k++) begin
        s2_chan[k] <= chan[k];
        s2_prod[k] <= {{VOL_W{1'b0}}, chan[k]} * {{BYTE_W{1'b0}}, s1.vol};
      end
    end
  end

  // Result register; hold while the sink stalls
  always_ff @(posedge clk) begin
    if (out_free) begin
      results.tx_valid  <= s2_tx_valid;
      results.tx_byte   <= s2_tx_byte;
      results.led_valid <= s2_led_valid;
      results.led_red   <= s2_led_valid ? level[0] : '0;
      results.led_green <= s2_led_valid ? level[1] : '0;
      results.led_blue  <= s2_led_valid ? level[2] : '0;
      results.mode_now  <= s2_mode;
    end
  end

endmodule

`default_nettype wire

[rtl/core/mute_knob_status_controller.sv]
// Top level: configuration registers, control stage, colour memory and scaling pipeline.
//
//   channel   dir   handshake      payload
//   items     in    valid/ready    cmd, rx_byte, rx_last
//   results   out   valid/ready    tx_valid, tx_byte, led_valid, led_red/green/blue, mode_now
//   cfg       in    valid/ready    index, data (ready always high)
//
// One item per cycle while ready is high. Each item gives one result through the control stage
// with colour read, the volume multiply and the divide by 100 into the result register.
// Ready drops only when all three stages hold items and the result sink stalls.
// Reset is synchronous; the colour table reads its base colours until loaded, no clearing pass.
`default_nettype none

module mute_knob_status_controller (
  input  logic        clk,
  input  logic        rst,
  mksc_in_if.sink     items,
  mksc_out_if.source  results,
  mksc_cfg_if.sink    cfg
);
  import mksc_pkg::*;

  cfg_t                cfg_regs;
  item_t               s1;
  logic                s1_valid;
  logic                take;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [COLOUR_W-1:0] ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [COLOUR_W-1:0] ram_rdata;

  assign cfg.ready = 1'b1;

  // Configuration registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.long_press   <= 16'd5000;
      cfg_regs.comm_timeout <= COMM_W'(15000);
      cfg_regs.led_max      <= 8'd255;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_LONG_PRESS:   cfg_regs.long_press   <= cfg.data;
        REG_COMM_TIMEOUT: cfg_regs.comm_timeout <= cfg.data;
        REG_LED_MAX:      cfg_regs.led_max      <= cfg.data[BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mksc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .cfg       (cfg_regs),
    .take      (take),
    .s1        (s1),
    .s1_valid  (s1_valid),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  mksc_colour_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mksc_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .s1       (s1),
    .s1_valid (s1_valid),
    .rdata    (ram_rdata),
    .take     (take),
    .results  (results)
  );

`ifndef SYNTHESIS
  // Input back-pressure only when a result is waiting at a stalled sink
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !items.ready |-> (results.valid && !results.ready))
    else $error("items not ready without a stalled result");

  // Outside a frame commit, a colour write never goes to the address that the table read selects
  a_write_spare_bank: assert property (@(posedge clk) disable iff (rst)
    (ram_we && !(items.valid && items.rx_last)) |-> (ram_waddr != ram_raddr))
    else $error("colour write hit the live bank outside a frame commit");

  // Reported mode stays within the mode range
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.mode_now <= IDLE_MODE))
    else $error("mode out of range");

  // A result with no host byte carries a zero byte
  a_tx_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.tx_valid) |-> (results.tx_byte == '0))
    else $error("tx byte set without tx valid");
`endif

endmodule

`default_nettype wire

[verif/mute_knob_status_controller_tb.sv]
// Self-checking testbench for the mute knob status controller: directed and random items.
`timescale 1ns / 100ps

module mute_knob_status_controller_tb;
  import mksc_pkg::*;

  localparam int STORE_DEPTH    = 3 * NUM_MODES;
  localparam int HOLD_CYCLES    = 120;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PRINT_CAP      = 40;

  // Commands the block must ignore
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
  // Register index outside the list, written to check it is ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic [COLOUR_W-1:0] BASE_COLOURS [NUM_MODES] = '{
    24'h001f00, 24'h1f0000, 24'h200030, 24'h574c3f, 24'h346596, 24'h200030, 24'h300030
  };
  localparam logic [BYTE_W-1:0] ALIVE_REQUEST [4] = '{8'h11, 8'h22, 8'h33, 8'h44};

  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              led_valid;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [MODE_W-1:0] mode_now;
  } knob_status_t;

  // Tracks knob, link and display state and the statuses still owed by the block
  class knob_status_board;
    logic [15:0]         long_press;
    logic [COMM_W-1:0]   comm_timeout;
    logic [BYTE_W-1:0]   led_max;
    logic [MODE_W-1:0]   mode;
    logic [MODE_W-1:0]   shown_mode;
    bit                  stale;
    logic [BYTE_W-1:0]   volume;
    logic [COLOUR_W-1:0] colours [NUM_MODES];
    logic [TICK_W-1:0]   ticks;
    logic [TICK_W-1:0]   press_at;
    logic [COMM_W-1:0]   since_comm;
    logic [BYTE_W-1:0]   frame_bytes [STORE_DEPTH];
    int                  frame_len;
    knob_status_t        due_status [$];
    int errors;
    int checked;
    int alive_replies;
    int long_unmutes;
    int colour_loads;
    int link_drops;

    function new();
      long_press   = 16'd5000;
      comm_timeout = 16'd15000;
      led_max      = 8'hff;
      mode         = IDLE_MODE;
      shown_mode   = '0;
      stale        = 1'b1;
      volume       = '0;
      colours      = BASE_COLOURS;
      ticks        = '0;
      press_at     = '0;
      since_comm   = '0;
      frame_len    = 0;
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
      errors        = 0;
      checked       = 0;
      alive_replies = 0;
      long_unmutes  = 0;
      colour_loads  = 0;
      link_drops    = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LONG_PRESS:   long_press = data;
        REG_COMM_TIMEOUT: comm_timeout = data;
        REG_LED_MAX:      led_max = data[BYTE_W-1:0];
        default: ;
      endcase
    endfunction

    // Scale one channel by level/100, keeping a lit channel lit
    function logic [BYTE_W-1:0] dim_channel(logic [BYTE_W-1:0] c, int level);
      int r;
      r = int'(c) * level / 100;
      if (r == 0 && c != 0) r = 1;
      return BYTE_W'(r);
    endfunction

    // Advance the state by one transferred item and queue the status it owes
    function void take_item(logic [CMD_W-1:0] c, logic [BYTE_W-1:0] b, logic last);
      knob_status_t e;
      int len;
      int n;
      int level;
      logic [BYTE_W-1:0] ch [3];
      e = '0;
      case (c)
        CMD_TICK: begin
          ticks = ticks + 1;
          if (since_comm != 16'hffff) since_comm = since_comm + 1;
        end
        CMD_PRESS: begin
          e.tx_valid = 1'b1;
          e.tx_byte  = (mode == MODE_MUTED) ? KEY_UNMUTE : KEY_MUTE;
          press_at   = ticks;
        end
        CMD_RELEASE: begin
          if (mode == MODE_MUTED && (ticks - press_at) > TICK_W'(long_press)) begin
            e.tx_valid = 1'b1;
            e.tx_byte  = KEY_UNMUTE;
            long_unmutes++;
          end
        end
        CMD_CW: begin
          e.tx_valid = 1'b1;
          e.tx_byte  = KEY_VOL_UP;
        end
        CMD_CCW: begin
          e.tx_valid = 1'b1;
          e.tx_byte  = KEY_VOL_DN;
        end
        CMD_FRAME: begin
          if (frame_len < STORE_DEPTH) frame_bytes[frame_len] = b;
          if (frame_len < FRAME_MAX) frame_len++;
          if (last) begin
            len        = frame_len;
            frame_len  = 0;
            since_comm = '0;
            if (len == 4) begin
              if (frame_bytes[0] == ALIVE_REQUEST[0] && frame_bytes[1] == ALIVE_REQUEST[1] &&
                  frame_bytes[2] == ALIVE_REQUEST[2] && frame_bytes[3] == ALIVE_REQUEST[3]) begin
                e.tx_valid = 1'b1;
                e.tx_byte  = ALIVE_REPLY;
                alive_replies++;
              end
            end else if (len == 2) begin
              mode   = (int'(frame_bytes[0]) >= NUM_MODES) ? IDLE_MODE : MODE_W'(frame_bytes[0]);
              volume = frame_bytes[1];
              stale  = 1'b1;
            end else if (len >= 3 && len % 3 == 0) begin
              n = (len / 3 > NUM_MODES) ? NUM_MODES : len / 3;
              for (int j = 0; j < n; j++) begin
                for (int k = 0; k < 3; k++) begin
                  ch[k] = (frame_bytes[3*j+k] > led_max) ? led_max : frame_bytes[3*j+k];
                end
                colours[j] = {ch[0], ch[1], ch[2]};
              end
              stale = 1'b1;
              colour_loads++;
            end
          end
        end
        default: ;
      endcase

      // Link timeout forces the idle mode
      if (since_comm > comm_timeout) begin
        if (mode != IDLE_MODE) link_drops++;
        mode = IDLE_MODE;
      end

      // Refresh the display when stale or when the mode changed
      if (stale || mode != shown_mode) begin
        shown_mode  = mode;
        stale       = 1'b0;
        e.led_valid = 1'b1;
        {e.red, e.green, e.blue} = colours[mode];
        if (mode <= MODE_MUTED) begin
          level   = (volume > 8'd100) ? 100 : int'(volume);
          e.red   = dim_channel(e.red, level);
          e.green = dim_channel(e.green, level);
          e.blue  = dim_channel(e.blue, level);
        end
      end
      e.mode_now = mode;
      due_status.push_back(e);
    endfunction

    function void field_check(string name, int want, int seen);
      if (want != seen) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, seen);
      end
    endfunction

    // Compare one transferred status with the oldest one owed
    function void check_status(knob_status_t got);
      knob_status_t e;
      if (due_status.size() == 0) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t: status with nothing owed, expected none, actual %p", $time, got);
        return;
      end
      e = due_status.pop_front();
      checked++;
      field_check("tx_valid", int'(e.tx_valid), int'(got.tx_valid));
      field_check("tx_byte", int'(e.tx_byte), int'(got.tx_byte));
      field_check("led_valid", int'(e.led_valid), int'(got.led_valid));
      field_check("led_red", int'(e.red), int'(got.red));
      field_check("led_green", int'(e.green), int'(got.green));
      field_check("led_blue", int'(e.blue), int'(got.blue));
      field_check("mode_now", int'(e.mode_now), int'(got.mode_now));
    endfunction
  endclass

  logic clk;
  logic rst;

  mksc_in_if  item_bus ();
  mksc_out_if status_bus ();
  mksc_cfg_if cfg_bus ();

  mute_knob_status_controller dut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_bus),
    .results (status_bus),
    .cfg     (cfg_bus)
  );

  knob_status_board model = new();

  int gap_pct       = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int sent_items    = 0;
  int quiet_cycles  = 0;
  logic [BYTE_W-1:0] frame_buf [$];

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sample every channel at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (item_bus.valid && item_bus.ready)
        model.take_item(item_bus.cmd, item_bus.rx_byte, item_bus.rx_last);
      if (cfg_bus.valid && cfg_bus.ready)
        model.write_register(cfg_bus.index, cfg_bus.data);
      if (status_bus.valid && status_bus.ready)
        model.check_status(knob_status_t'{status_bus.tx_valid, status_bus.tx_byte,
                                          status_bus.led_valid, status_bus.led_red,
                                          status_bus.led_green, status_bus.led_blue,
                                          status_bus.mode_now});
    end
  end

  // Stop a hung run: count cycles with no transfer anywhere
  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) || (status_bus.valid && status_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("mute_knob_status_controller regression: fail");
      $finish;
    end
  end

  // Status sink: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    status_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        status_bus.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (hold_requests != holds_served) begin
        holds_served = holds_served + 1;
        hold_left = HOLD_CYCLES - 1;
        status_bus.ready <= 1'b0;
      end else begin
        status_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Offer one item, with random gaps, and hold it until transferred
  task automatic send_item(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] b,
                           input logic last);
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      item_bus.valid   <= 1'b0;
      item_bus.cmd     <= CMD_W'($urandom);
      item_bus.rx_byte <= BYTE_W'($urandom);
      item_bus.rx_last <= 1'($urandom);
      @(negedge clk);
    end
    item_bus.valid   <= 1'b1;
    item_bus.cmd     <= c;
    item_bus.rx_byte <= b;
    item_bus.rx_last <= last;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    if (c <= CMD_FRAME) sent_items++;
  endtask

  // Non-frame command with junk in the frame fields
  task automatic send_cmd(input logic [CMD_W-1:0] c);
    send_item(c, BYTE_W'($urandom), 1'($urandom));
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++)
      send_item(CMD_FRAME, frame_buf[i], i == frame_buf.size() - 1);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] long_press, input logic [15:0] timeout,
                            input logic [7:0] led_max);
    write_reg(REG_LONG_PRESS, long_press);
    write_reg(REG_COMM_TIMEOUT, timeout);
    write_reg(REG_LED_MAX, {8'($urandom), led_max});
  endtask

  // Drop valid, wait for every owed status, then let the pipeline settle
  task automatic end_phase();
    @(negedge clk);
    item_bus.valid <= 1'b0;
    while (model.due_status.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly well-formed knob and frame sequences, some noise
  task automatic run_random(input int count);
    int goal;
    int pick;
    int n;
    goal = sent_items + count;
    while (sent_items < goal) begin
      pick = int'($urandom_range(0, 99));
      frame_buf.delete();
      if (pick < 14) begin
        repeat ($urandom_range(1, 6)) send_cmd(CMD_TICK);
      end else if (pick < 24) begin
        repeat ($urandom_range(1, 3)) send_cmd($urandom_range(0, 1) ? CMD_CW : CMD_CCW);
      end else if (pick < 40) begin
        // Mostly mute first, then press, wait around the long-press threshold where it is short, release
        if ($urandom_range(0, 3) != 0) begin
          frame_buf.push_back(BYTE_W'(MODE_MUTED));
          frame_buf.push_back(BYTE_W'($urandom));
          send_frame();
        end
        send_cmd(CMD_PRESS);
        if (model.long_press <= 16'd30)
          n = int'(model.long_press) + int'($urandom_range(0, 2)) - 1;
        else
          n = int'($urandom_range(0, 4));
        repeat (n) send_cmd(CMD_TICK);
        send_cmd(CMD_RELEASE);
      end else if (pick < 52) begin
        case ($urandom_range(0, 4))
          0:       frame_buf.push_back(8'd0);
          1, 2:    frame_buf.push_back(BYTE_W'(MODE_MUTED));
          3:       frame_buf.push_back(BYTE_W'(IDLE_MODE));
          default: frame_buf.push_back(BYTE_W'($urandom));
        endcase
        case ($urandom_range(0, 6))
          0:       frame_buf.push_back(8'd0);
          1:       frame_buf.push_back(8'd1);
          2:       frame_buf.push_back(8'd99);
          3:       frame_buf.push_back(8'd100);
          4:       frame_buf.push_back(8'd101);
          5:       frame_buf.push_back(8'd255);
          default: frame_buf.push_back(BYTE_W'($urandom));
        endcase
        send_frame();
      end else if (pick < 62) begin
        // Keep-alive request, sometimes corrupted
        for (int i = 0; i < 4; i++) frame_buf.push_back(ALIVE_REQUEST[i]);
        if ($urandom_range(0, 3) == 0) frame_buf[$urandom_range(0, 3)] = BYTE_W'($urandom);
        send_frame();
      end else if (pick < 77) begin
        n = 3 * int'($urandom_range(1, 8));
        repeat (n) begin
          case ($urandom_range(0, 3))
            0:       frame_buf.push_back(8'd0);
            1:       frame_buf.push_back(8'hff);
            default: frame_buf.push_back(BYTE_W'($urandom));
          endcase
        end
        send_frame();
      end else if (pick < 86) begin
        repeat ($urandom_range(1, 25)) frame_buf.push_back(BYTE_W'($urandom));
        send_frame();
      end else if (pick < 90) begin
        // Quiet link, running to around the timeout where it is short
        if (model.comm_timeout <= 16'd100)
          n = int'(model.comm_timeout) + int'($urandom_range(0, 4)) - 2;
        else
          n = int'($urandom_range(5, 30));
        repeat (n) send_cmd(CMD_TICK);
      end else begin
        repeat ($urandom_range(1, 4))
          send_item(CMD_W'($urandom), BYTE_W'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    rst              = 1'b1;
    item_bus.valid   = 1'b0;
    item_bus.cmd     = CMD_TICK;
    item_bus.rx_byte = '0;
    item_bus.rx_last = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = REG_LONG_PRESS;
    cfg_bus.data     = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every command, keep-alive, mode saturation, volume extremes, colour load
    send_cmd(CMD_TICK);
    send_cmd(CMD_CW);
    send_cmd(CMD_CCW);
    send_cmd(CMD_PRESS);
    send_cmd(CMD_RELEASE);
    send_cmd(CMD_SPARE_A);
    send_cmd(CMD_SPARE_B);
    send_item(CMD_FRAME, 8'h11, 1'b0);
    send_item(CMD_FRAME, 8'h22, 1'b0);
    send_item(CMD_FRAME, 8'h33, 1'b0);
    send_item(CMD_FRAME, 8'h44, 1'b1);
    send_item(CMD_FRAME, 8'h01, 1'b0);
    send_item(CMD_FRAME, 8'hff, 1'b1);
    send_cmd(CMD_PRESS);
    send_cmd(CMD_RELEASE);
    send_item(CMD_FRAME, 8'h00, 1'b0);
    send_item(CMD_FRAME, 8'h00, 1'b1);
    send_item(CMD_FRAME, 8'hff, 1'b0);
    send_item(CMD_FRAME, 8'h00, 1'b0);
    send_item(CMD_FRAME, 8'h80, 1'b1);
    send_item(CMD_FRAME, 8'h00, 1'b0);
    send_item(CMD_FRAME, 8'd100, 1'b1);
    send_item(CMD_FRAME, 8'hff, 1'b0);
    send_item(CMD_FRAME, 8'd100, 1'b1);
    send_item(CMD_FRAME, 8'h5a, 1'b1);
    end_phase();

    // All-zero settings, no idling
    set_config(16'd0, 16'd0, 8'd0);
    gap_pct   = 0;
    stall_pct = 0;
    run_random(260);
    end_phase();

    // Short thresholds, sender mostly idle
    set_config(16'd3, 16'd40, 8'h80);
    gap_pct   = 71;
    stall_pct = 0;
    run_random(260);
    end_phase();

    // All-ones settings, sink stalling, with one long hold-off while items keep coming
    set_config(16'hffff, 16'hffff, 8'hff);
    gap_pct   = 0;
    stall_pct = 71;
    hold_requests++;
    run_random(260);
    end_phase();

    // Middle settings, light idling on both sides, then a frame past the length limit
    set_config(16'd12, 16'd60, 8'd200);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    gap_pct   = 10;
    stall_pct = 10;
    run_random(260);
    frame_buf.delete();
    repeat (FRAME_MAX + 2) frame_buf.push_back(BYTE_W'($urandom));
    send_frame();
    run_random(20);
    end_phase();

    model.errors += model.due_status.size();
    $display("Ran %0d items, checked %0d statuses: %0d keep-alive replies, %0d long-press unmutes,",
             sent_items, model.checked, model.alive_replies, model.long_unmutes);
    $display("%0d colour loads and %0d link timeouts over four register settings.",
             model.colour_loads, model.link_drops);
    if (model.errors == 0) begin
      $display("mute_knob_status_controller regression: pass");
    end else begin
      $display("%0d mismatches", model.errors);
      $display("mute_knob_status_controller regression: fail");
    end
    $finish;
  end

endmodule
